### design/tcpq_pkg.sv
`timescale 1ns / 1ps

package tcpq_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int OCC_W       = 4;
  localparam int TIME_WIDTH  = 32;
  localparam int CNT_W       = 32;
  localparam int SUM_W       = 40;
  localparam int ARR_W       = 4;

  localparam logic [OCC_W-1:0] CAP_RESET = 4'd5;
  localparam logic [OCC_W-1:0] CAP_MAX   = OCC_W'(QUEUE_DEPTH);

  typedef logic [1:0] class_code_t;
  localparam class_code_t CLS_IDLE = 2'd0;
  localparam class_code_t CLS_HIGH = 2'd1;
  localparam class_code_t CLS_LOW  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ARRIVE,
    ST_PUSH_H,
    ST_PUSH_L,
    ST_READ,
    ST_SERVE
  } ctl_state_t;

  typedef struct packed {
    logic [ARR_W-1:0] high_arrivals;
    logic [ARR_W-1:0] low_arrivals;
  } in_word_t;

  typedef struct packed {
    class_code_t      served_class;
    logic [31:0]      served_wait;
    logic [CNT_W-1:0] arrivals_total;
    logic [CNT_W-1:0] high_served_total;
    logic [CNT_W-1:0] low_served_total;
    logic [CNT_W-1:0] high_refused_total;
    logic [CNT_W-1:0] low_refused_total;
    logic [CNT_W-1:0] idle_total;
    logic [SUM_W-1:0] high_wait_sum;
    logic [SUM_W-1:0] low_wait_sum;
    logic [OCC_W-1:0] high_occupancy;
    logic [OCC_W-1:0] low_occupancy;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic latch;
    logic arrive;
    logic push_h;
    logic push_l;
    logic read;
    logic serve;
  } tcpq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic h_last;
    logic l_last;
  } tcpq_stat_t;

  function automatic logic [CNT_W-1:0] sat_add_cnt(input logic [CNT_W-1:0] a,
                                                   input logic [ARR_W:0]   b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {{(CNT_W-ARR_W){1'b0}}, b};
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

  function automatic logic [SUM_W-1:0] sat_add_sum(input logic [SUM_W-1:0]      a,
                                                   input logic [TIME_WIDTH-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {{(SUM_W+1-TIME_WIDTH){1'b0}}, b};
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

endpackage

### design/tcpq_ctrl.sv
`timescale 1ns / 1ps

module tcpq_ctrl
  import tcpq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  tcpq_stat_t stat,
  output tcpq_cmd_t  cmd,
  output logic       busy
);

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (start) state_nxt = ST_ARRIVE;
      ST_ARRIVE: state_nxt = ST_PUSH_H;
      ST_PUSH_H: if (stat.h_last) state_nxt = ST_PUSH_L;
      ST_PUSH_L: if (stat.l_last) state_nxt = ST_READ;
      ST_READ:   state_nxt = ST_SERVE;
      ST_SERVE:  state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy      = 1'b0;
        cmd.latch = start;
      end
      ST_ARRIVE: cmd.arrive = 1'b1;
      ST_PUSH_H: cmd.push_h = 1'b1;
      ST_PUSH_L: cmd.push_l = 1'b1;
      ST_READ:   cmd.read   = 1'b1;
      ST_SERVE:  cmd.serve  = 1'b1;
      default:   busy = 1'b1;
    endcase
  end

`ifndef ASSERT_OFF
  // a tick always ends with exactly one serve step before going idle
  a_serve_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SERVE |=> state_r == ST_IDLE)
    else $error("serve step not followed by idle");

  // the serve step is reached only through the read step
  a_read_before_serve: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SERVE |-> $past(state_r) == ST_READ)
    else $error("serve step without a stamp read");

  // a new word is taken only from idle
  a_latch_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.latch |-> (state_r == ST_IDLE && !busy))
    else $error("word latched while busy");
`endif

endmodule

### design/tcpq_dp.sv
`timescale 1ns / 1ps

module tcpq_dp
  import tcpq_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  tcpq_cmd_t        cmd,
  input  in_word_t         in_word,
  input  logic             cfg_we,
  input  logic [OCC_W-1:0] cfg_wdata,
  output tcpq_stat_t       stat,
  output out_word_t        out_word,
  output logic             out_valid
);

  logic [TIME_WIDTH-1:0] mem_h [QUEUE_DEPTH];
  logic [TIME_WIDTH-1:0] mem_l [QUEUE_DEPTH];

  logic [OCC_W-1:0]      cap_r;
  logic [TIME_WIDTH-1:0] tick_r;
  logic [ARR_W-1:0]      ha_r, la_r;
  logic [OCC_W-1:0]      h_left_r, l_left_r;
  logic [PTR_W-1:0]      h_head_r, h_tail_r, l_head_r, l_tail_r;
  logic [OCC_W-1:0]      h_count_r, l_count_r;
  logic [TIME_WIDTH-1:0] stamp_r;
  class_code_t           cls_r;
  logic                  out_valid_r;
  class_code_t           served_class_r;
  logic [31:0]           served_wait_r;
  logic [CNT_W-1:0]      arr_tot_r, h_srv_r, l_srv_r, h_ref_r, l_ref_r, idle_r;
  logic [SUM_W-1:0]      h_sum_r, l_sum_r;

  logic [OCC_W-1:0]      cap_eff;
  logic [OCC_W-1:0]      h_avail, l_avail, h_acc, l_acc;
  logic [ARR_W-1:0]      h_ref, l_ref;
  logic [TIME_WIDTH-1:0] wait_now;

  // zero reads as one, anything above the ring depth is clamped
  always_comb begin
    priority if (cap_r == '0) begin
      cap_eff = 4'd1;
    end else if (cap_r > CAP_MAX) begin
      cap_eff = CAP_MAX;
    end else begin
      cap_eff = cap_r;
    end
  end

  assign h_avail = (h_count_r >= cap_eff) ? '0 : cap_eff - h_count_r;
  assign l_avail = (l_count_r >= cap_eff) ? '0 : cap_eff - l_count_r;
  assign h_acc   = (ha_r < h_avail) ? ha_r : h_avail;
  assign l_acc   = (la_r < l_avail) ? la_r : l_avail;
  assign h_ref   = ha_r - h_acc;
  assign l_ref   = la_r - l_acc;
  assign wait_now = tick_r - stamp_r;

  assign stat.h_last = (h_left_r <= 4'd1);
  assign stat.l_last = (l_left_r <= 4'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  // stamp stores, no reset
  always_ff @(posedge clk) begin
    if (cmd.push_h && h_left_r != '0) begin
      mem_h[h_tail_r] <= tick_r;
    end
    if (cmd.push_l && l_left_r != '0) begin
      mem_l[l_tail_r] <= tick_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      ha_r <= in_word.high_arrivals;
      la_r <= in_word.low_arrivals;
    end
    if (cmd.read) begin
      stamp_r <= (h_count_r != '0) ? mem_h[h_head_r] : mem_l[l_head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r         <= {{(TIME_WIDTH-1){1'b0}}, 1'b1};
      h_left_r       <= '0;
      l_left_r       <= '0;
      h_head_r       <= '0;
      h_tail_r       <= '0;
      l_head_r       <= '0;
      l_tail_r       <= '0;
      h_count_r      <= '0;
      l_count_r      <= '0;
      cls_r          <= CLS_IDLE;
      out_valid_r    <= 1'b0;
      served_class_r <= CLS_IDLE;
      served_wait_r  <= '0;
      arr_tot_r      <= '0;
      h_srv_r        <= '0;
      l_srv_r        <= '0;
      h_ref_r        <= '0;
      l_ref_r        <= '0;
      idle_r         <= '0;
      h_sum_r        <= '0;
      l_sum_r        <= '0;
    end else begin
      out_valid_r <= cmd.serve;
      if (cmd.arrive) begin
        arr_tot_r <= sat_add_cnt(arr_tot_r, {1'b0, ha_r} + {1'b0, la_r});
        h_ref_r   <= sat_add_cnt(h_ref_r, {1'b0, h_ref});
        l_ref_r   <= sat_add_cnt(l_ref_r, {1'b0, l_ref});
        h_left_r  <= h_acc;
        l_left_r  <= l_acc;
      end
      if (cmd.push_h && h_left_r != '0) begin
        h_tail_r  <= h_tail_r + 1'b1;
        h_count_r <= h_count_r + 1'b1;
        h_left_r  <= h_left_r - 1'b1;
      end
      if (cmd.push_l && l_left_r != '0) begin
        l_tail_r  <= l_tail_r + 1'b1;
        l_count_r <= l_count_r + 1'b1;
        l_left_r  <= l_left_r - 1'b1;
      end
      if (cmd.read) begin
        priority if (h_count_r != '0) begin
          cls_r <= CLS_HIGH;
        end else if (l_count_r != '0) begin
          cls_r <= CLS_LOW;
        end else begin
          cls_r <= CLS_IDLE;
        end
      end
      if (cmd.serve) begin
        served_class_r <= cls_r;
        tick_r         <= tick_r + 1'b1;
        unique case (cls_r)
          CLS_HIGH: begin
            served_wait_r <= wait_now;
            h_head_r      <= h_head_r + 1'b1;
            h_count_r     <= h_count_r - 1'b1;
            h_srv_r       <= sat_add_cnt(h_srv_r, 5'd1);
            h_sum_r       <= sat_add_sum(h_sum_r, wait_now);
          end
          CLS_LOW: begin
            served_wait_r <= wait_now;
            l_head_r      <= l_head_r + 1'b1;
            l_count_r     <= l_count_r - 1'b1;
            l_srv_r       <= sat_add_cnt(l_srv_r, 5'd1);
            l_sum_r       <= sat_add_sum(l_sum_r, wait_now);
          end
          default: begin
            served_wait_r <= '0;
            idle_r        <= sat_add_cnt(idle_r, 5'd1);
          end
        endcase
      end
    end
  end

  assign out_valid                   = out_valid_r;
  assign out_word.served_class       = served_class_r;
  assign out_word.served_wait        = served_wait_r;
  assign out_word.arrivals_total     = arr_tot_r;
  assign out_word.high_served_total  = h_srv_r;
  assign out_word.low_served_total   = l_srv_r;
  assign out_word.high_refused_total = h_ref_r;
  assign out_word.low_refused_total  = l_ref_r;
  assign out_word.idle_total         = idle_r;
  assign out_word.high_wait_sum      = h_sum_r;
  assign out_word.low_wait_sum       = l_sum_r;
  assign out_word.high_occupancy     = h_count_r;
  assign out_word.low_occupancy      = l_count_r;

`ifndef ASSERT_OFF
  // occupancy never passes the ring depth
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    h_count_r <= CAP_MAX && l_count_r <= CAP_MAX)
    else $error("queue occupancy beyond ring depth");

  // ring pointers agree with the occupancy count
  a_ring_h: assert property (@(posedge clk) disable iff (!rst_n)
    (h_tail_r - h_head_r) == h_count_r[PTR_W-1:0])
    else $error("high ring pointers disagree with count");

  a_ring_l: assert property (@(posedge clk) disable iff (!rst_n)
    (l_tail_r - l_head_r) == l_count_r[PTR_W-1:0])
    else $error("low ring pointers disagree with count");

  // an idle tick reports no wait
  a_idle_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && served_class_r == CLS_IDLE) |-> served_wait_r == '0)
    else $error("idle tick with nonzero wait");
`endif

endmodule

### design/two_class_priority_queue_stats.sv
`timescale 1ns / 1ps

// Strict-priority two-class scheduler with tail drop and running statistics.
// Each word taken on start (while busy is low) is one tick: its high and low
// arrival counts are first checked against the configured queue capacity,
// refused arrivals are counted, and the accepted ones are pushed one per
// cycle into their class ring, stamped with the tick number. Then one entry,
// if any, is served, high class first, and its wait is added to the class
// wait sum; a tick with both rings empty is counted as idle. One result
// word appears on out_word with out_valid high for exactly one cycle; the
// receiver cannot stall it, so it must take it then. A tick lasts longer
// the more arrivals are accepted, since the stamp stores take one write per
// cycle; start may be raised again in the cycle the strobe shows.
// cfg_we/cfg_wdata write the queue capacity (0 acts as 1, above 8 acts as 8)
// and should only be used while idle. All counters saturate.

module two_class_priority_queue_stats
  import tcpq_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_word_t         in_word,
  input  logic             cfg_we,
  input  logic [OCC_W-1:0] cfg_wdata,
  output logic             out_valid,
  output out_word_t        out_word
);

  tcpq_cmd_t  cmd;
  tcpq_stat_t stat;

  // sequence the arrive, push, read and serve steps
  tcpq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // hold the rings, stamps and statistics
  tcpq_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_word   (in_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .stat      (stat),
    .out_word  (out_word),
    .out_valid (out_valid)
  );

endmodule
